[rtl/pnf_pkg.sv]
// ---------------------------------------------------------------------------
// pnf_pkg: shared types and constants for the 3-D fractal gradient noise block
// Item structs, fixed-point widths, register indexes and the micro-op table.
// ---------------------------------------------------------------------------
package pnf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WGT_BITS  = 16;
  localparam int TBL_BITS  = 8;
  localparam int TBL_DEPTH = 1 << TBL_BITS;
  localparam int MAX_OCT   = 16;
  localparam int OCT_W     = 5;
  localparam int SHAMT_W   = 4;
  localparam int PERS_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 32;
  localparam int SHIFT_W   = COORD_W + MAX_OCT - 1;
  localparam int OFF_W     = FRAC_BITS + 2;
  localparam int DOT_W     = OFF_W + 1;
  localparam int VAL_W     = 34;
  localparam int ACC_W     = 40;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int RND_W     = PROD_W - FRAC_BITS;
  localparam int OP_W      = 5;
  localparam int OP_LAST   = 23;
  localparam int HASH_LAST = 13;

  localparam logic signed [VAL_W-1:0] ONE_V   = VAL_W'(64'd1 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0] K15     = VAL_W'(64'd15 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0] K10     = VAL_W'(64'd10 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0] WGT_ONE = VAL_W'(64'd1 << WGT_BITS);
  localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_OCT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURB = 2'd2;

  localparam logic [2:0] FS_V  = 3'd0;
  localparam logic [2:0] FS_W  = 3'd1;
  localparam logic [2:0] FS_T2 = 3'd2;
  localparam logic [2:0] FS_T3 = 3'd3;
  localparam logic [2:0] FS_F  = 3'd4;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [TBL_BITS-1:0]       entry_index;
    logic [TBL_BITS-1:0]       entry_value;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] noise_value;
    logic                      saturated;
  } out_item_t;

  typedef enum logic [1:0] {OP_FADE, OP_LERP, OP_CONTRIB, OP_WEIGHT} op_cls_t;

  typedef struct packed {
    op_cls_t    cls;
    logic [1:0] axis;
    logic [2:0] step;
    logic [1:0] lf;
    logic [2:0] dst;
  } op_t;

  // fifteen fade products (five per axis), seven lerps, contribution, weight
  function automatic op_t op_decode(input logic [OP_W-1:0] m);
    op_t o;
    o.cls  = OP_WEIGHT;
    o.axis = 2'd0;
    o.step = 3'd0;
    o.lf   = 2'd0;
    o.dst  = 3'd0;
    if (m < 5'd5) begin
      o.cls  = OP_FADE;
      o.step = m[2:0];
    end else if (m < 5'd10) begin
      o.cls  = OP_FADE;
      o.axis = 2'd1;
      o.step = 3'(m - 5'd5);
    end else if (m < 5'd15) begin
      o.cls  = OP_FADE;
      o.axis = 2'd2;
      o.step = 3'(m - 5'd10);
    end else if (m < 5'd22) begin
      o.cls = OP_LERP;
      o.dst = 3'(5'd21 - m);
      o.lf  = (m < 5'd19) ? 2'd0 : ((m < 5'd21) ? 2'd1 : 2'd2);
    end else if (m == 5'd22) begin
      o.cls = OP_CONTRIB;
    end
    return o;
  endfunction

  function automatic logic signed [DOT_W-1:0] grad_dot(input logic [3:0] h,
                                                        input logic signed [OFF_W-1:0] x,
                                                        input logic signed [OFF_W-1:0] y,
                                                        input logic signed [OFF_W-1:0] z);
    logic signed [DOT_W-1:0] ex, ey, ez, r;
    ex = DOT_W'(x);
    ey = DOT_W'(y);
    ez = DOT_W'(z);
    case (h)
      4'd0:    r = ex + ey;
      4'd1:    r = ey - ex;
      4'd2:    r = ex - ey;
      4'd3:    r = -ex - ey;
      4'd4:    r = ex + ez;
      4'd5:    r = ez - ex;
      4'd6:    r = ex - ez;
      4'd7:    r = -ex - ez;
      4'd8:    r = ey + ez;
      4'd9:    r = ez - ey;
      4'd10:   r = ey - ez;
      4'd11:   r = -ey - ez;
      4'd12:   r = ex + ey;
      4'd13:   r = ey - ex;
      4'd14:   r = ez - ey;
      default: r = -ey - ez;
    endcase
    return r;
  endfunction

endpackage

[rtl/perlin_noise_3d_fbm.sv]
// ---------------------------------------------------------------------------
// perlin_noise_3d_fbm: 3-D improved gradient noise summed over octaves
// Permutation table in a synchronous RAM, one shared multiplier, sequencer.
// ---------------------------------------------------------------------------
// A load beat (kind 1) writes one permutation entry and never raises busy.
// An evaluate beat keeps busy high through, per octave (n of them, n being
// the clamped octave count), one set-up state, the fourteen dependent
// table reads through the single RAM port (address and data state each),
// and the 24 products through the one shared multiplier (multiply and
// write-back state each), then a done state. The result is shown with
// out_strobe for one cycle, as busy falls; the receiver must take it then.
// The table must be loaded before evaluating; unwritten entries read junk.
module perlin_noise_3d_fbm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  pnf_pkg::in_item_t                  in_item,
  output logic                               out_strobe,
  output pnf_pkg::out_item_t                 out_item,
  input  logic                               cfg_we,
  input  logic [pnf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pnf_pkg::PERS_W-1:0]         cfg_wdata
);
  import pnf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_RD_ADDR, S_RD_DATA, S_MUL, S_WB, S_DONE
  } state_t;

  state_t state_r;

  logic [OCT_W-1:0]          oct_cnt_r;
  logic [PERS_W-1:0]         pers_r;
  logic                      turb_r;

  logic signed [COORD_W-1:0] pos_r [3];
  logic [OCT_W-1:0]          n_r;
  logic [OCT_W-1:0]          oi_r;
  logic [3:0]                h_r;
  logic [OP_W-1:0]           m_r;
  logic [TBL_BITS-1:0]       base_r [3];
  logic [FRAC_BITS-1:0]      t_r [3];
  logic [TBL_BITS-1:0]       hx_r [2];
  logic [TBL_BITS-1:0]       hy_r [4];
  logic signed [VAL_W-1:0]   q_r [8];
  logic signed [VAL_W-1:0]   v_r, w_r, t2_r, t3_r;
  logic signed [VAL_W-1:0]   fade_r [3];
  logic signed [VAL_W-1:0]   weight_r;
  logic signed [ACC_W-1:0]   sum_r;
  out_item_t                 out_r;
  logic                      strobe_r;

  logic                      accept;
  logic                      ram_we;
  logic [TBL_BITS-1:0]       ram_addr;
  logic [TBL_BITS-1:0]       rd_addr;
  logic [TBL_BITS-1:0]       ram_rdata;
  logic [1:0]                jy;
  logic [2:0]                jz;
  logic [SHIFT_W-1:0]        sh [3];
  logic signed [OFF_W-1:0]   off [3];
  logic [OCT_W-1:0]          n_clamp;
  op_t                       op;
  logic signed [VAL_W-1:0]   t_val;
  logic signed [VAL_W-1:0]   oct_abs;
  logic signed [VAL_W-1:0]   mul_a, mul_b;
  logic signed [RND_W-1:0]   rnd;
  logic signed [VAL_W-1:0]   r_v;
  logic [ACC_W-COORD_W:0]    top_bits;

  assign accept     = start && (state_r == S_IDLE);
  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  assign n_clamp = (oct_cnt_r > OCT_W'(MAX_OCT)) ? OCT_W'(MAX_OCT) : oct_cnt_r;

  // hash address: two x reads, four y reads, eight z reads
  assign jy = 2'(h_r - 4'd2);
  assign jz = 3'(h_r - 4'd6);

  always_comb begin
    if (h_r < 4'd2) begin
      rd_addr = base_r[0] + TBL_BITS'(h_r[0]);
    end else if (h_r < 4'd6) begin
      rd_addr = hx_r[jy[1]] + base_r[1] + TBL_BITS'(jy[0]);
    end else begin
      rd_addr = hy_r[jz[2:1]] + base_r[2] + TBL_BITS'(jz[0]);
    end
  end

  assign ram_we   = accept && in_item.kind;
  assign ram_addr = (state_r == S_IDLE) ? in_item.entry_index : rd_addr;

  pnf_ram #(
    .WIDTH (TBL_BITS),
    .DEPTH (TBL_DEPTH)
  ) u_perm (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_item.entry_value),
    .rdata (ram_rdata)
  );

  // scaled coordinates and corner offsets
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sh[a] = SHIFT_W'(pos_r[a]) << oi_r[SHAMT_W-1:0];
    end
    off[0] = OFF_W'({1'b0, t_r[0]}) - (jz[2] ? OFF_W'(ONE_V) : OFF_W'(0));
    off[1] = OFF_W'({1'b0, t_r[1]}) - (jz[1] ? OFF_W'(ONE_V) : OFF_W'(0));
    off[2] = OFF_W'({1'b0, t_r[2]}) - (jz[0] ? OFF_W'(ONE_V) : OFF_W'(0));
  end

  // multiplier operand selection
  assign op      = op_decode(m_r);
  assign t_val   = VAL_W'({1'b0, t_r[op.axis]});
  assign oct_abs = (turb_r && q_r[0][VAL_W-1]) ? -q_r[0] : q_r[0];

  always_comb begin
    mul_a = weight_r;
    mul_b = VAL_W'(pers_r);
    case (op.cls)
      OP_FADE: begin
        mul_a = t_val;
        mul_b = t_val;
        case (op.step)
          FS_V:    mul_b = (t_val <<< 2) + (t_val <<< 1) - K15;
          FS_W:    mul_b = v_r;
          FS_T2:   mul_b = t_val;
          FS_T3:   mul_a = t2_r;
          FS_F: begin
            mul_a = t3_r;
            mul_b = w_r;
          end
          default: mul_b = t_val;
        endcase
      end
      OP_LERP: begin
        mul_a = fade_r[op.lf];
        mul_b = q_r[1] - q_r[0];
      end
      OP_CONTRIB: begin
        mul_a = oct_abs;
        mul_b = weight_r;
      end
      default: begin
        mul_a = weight_r;
        mul_b = VAL_W'(pers_r);
      end
    endcase
  end

  pnf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .rnd (rnd)
  );

  assign r_v      = rnd[VAL_W-1:0];
  assign top_bits = sum_r[ACC_W-1:COORD_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      oct_cnt_r <= OCT_W'(1);
      pers_r    <= PERS_W'(32768);
      turb_r    <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_OCT:  oct_cnt_r <= cfg_wdata[OCT_W-1:0];
          CFG_PERS: pers_r    <= cfg_wdata;
          CFG_TURB: turb_r    <= cfg_wdata[0];
          default:  ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept && !in_item.kind) begin
            pos_r[0] <= in_item.pos_x;
            pos_r[1] <= in_item.pos_y;
            pos_r[2] <= in_item.pos_z;
            n_r      <= n_clamp;
            oi_r     <= '0;
            weight_r <= WGT_ONE;
            sum_r    <= '0;
            state_r  <= (n_clamp == '0) ? S_DONE : S_SETUP;
          end
        end
        S_SETUP: begin
          for (int a = 0; a < 3; a++) begin
            base_r[a] <= sh[a][FRAC_BITS+TBL_BITS-1:FRAC_BITS];
            t_r[a]    <= sh[a][FRAC_BITS-1:0];
          end
          h_r     <= '0;
          state_r <= S_RD_ADDR;
        end
        S_RD_ADDR: begin
          state_r <= S_RD_DATA;
        end
        S_RD_DATA: begin
          if (h_r < 4'd2) begin
            hx_r[h_r[0]] <= ram_rdata;
          end else if (h_r < 4'd6) begin
            hy_r[jy] <= ram_rdata;
          end else begin
            // corners kept x-innermost so each lerp pairs the two head entries
            q_r[{jz[0], jz[1], jz[2]}] <=
              VAL_W'(grad_dot(ram_rdata[3:0], off[0], off[1], off[2]));
          end
          h_r <= h_r + 4'd1;
          if (h_r == 4'(HASH_LAST)) begin
            m_r     <= '0;
            state_r <= S_MUL;
          end else begin
            state_r <= S_RD_ADDR;
          end
        end
        S_MUL: begin
          state_r <= S_WB;
        end
        S_WB: begin
          case (op.cls)
            OP_FADE: begin
              case (op.step)
                FS_V:    v_r  <= r_v + K10;
                FS_W:    w_r  <= r_v;
                FS_T2:   t2_r <= r_v;
                FS_T3:   t3_r <= r_v;
                default: fade_r[op.axis] <= r_v;
              endcase
            end
            OP_LERP: begin
              // pop two from the head, push the blend at the tail
              for (int i = 0; i < 6; i++) begin
                q_r[i] <= q_r[i+2];
              end
              q_r[op.dst] <= q_r[0] + r_v;
            end
            OP_CONTRIB: sum_r    <= sum_r + ACC_W'(rnd);
            default:    weight_r <= r_v;
          endcase
          m_r <= m_r + OP_W'(1);
          if (m_r == OP_W'(OP_LAST)) begin
            oi_r    <= oi_r + OCT_W'(1);
            state_r <= (oi_r + OCT_W'(1) == n_r) ? S_DONE : S_SETUP;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_DONE: begin
          strobe_r <= 1'b1;
          if (!sum_r[ACC_W-1] && (|top_bits)) begin
            out_r.noise_value <= SAT_MAX;
            out_r.saturated   <= 1'b1;
          end else if (sum_r[ACC_W-1] && !(&top_bits)) begin
            out_r.noise_value <= SAT_MIN;
            out_r.saturated   <= 1'b1;
          end else begin
            out_r.noise_value <= sum_r[COORD_W-1:0];
            out_r.saturated   <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/pnf_ram.sv]
// ---------------------------------------------------------------------------
// pnf_ram: generic single-port synchronous RAM
// One address for write or read; read data registered.
// ---------------------------------------------------------------------------
module pnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/pnf_mul.sv]
// ---------------------------------------------------------------------------
// pnf_mul: shared signed multiplier with round-to-nearest
// Product registered; rounded result (ties up) formed combinationally from it.
// ---------------------------------------------------------------------------
module pnf_mul (
  input  logic                             clk,
  input  logic signed [pnf_pkg::VAL_W-1:0] a,
  input  logic signed [pnf_pkg::VAL_W-1:0] b,
  output logic signed [pnf_pkg::RND_W-1:0] rnd
);
  import pnf_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic signed [PROD_W-1:0] p_r;
  logic signed [PROD_W-1:0] biased;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign biased = p_r + HALF;
  assign rnd    = biased[PROD_W-1:FRAC_BITS];

endmodule
